### hdl/b64d_pkg.sv
// Shared types, codes and the character decode function of the base64 stream decoder.
// Used by the top level, front, queue and back modules; depends on nothing else.
`default_nettype none

package b64d_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam logic [7:0]  PAD_CHAR    = 8'h3D;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ILLEGAL = 2'd1,
    ST_LENGTH  = 2'd2
  } b64d_status_e;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } b64d_kind_e;

  typedef struct packed {
    b64d_kind_e   kind;
    logic [7:0]   data_byte;
    b64d_status_e status;
    logic         last;
  } b64d_item_t;

  // One queue entry holds every result that a single character causes.
  typedef struct packed {
    logic       two;
    b64d_item_t first;
    b64d_item_t second;
  } b64d_op_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] sextet;
  } b64d_dec_t;

  function automatic b64d_dec_t b64d_decode(input logic [7:0] c);
    b64d_dec_t  res;
    logic [7:0] diff;
    res  = '{valid: 1'b1, sextet: 6'd0};
    diff = 8'd0;
    case (c) inside
      [8'h41:8'h5A]: begin
        diff       = c - 8'h41;
        res.sextet = diff[5:0];
      end
      [8'h61:8'h7A]: begin
        diff       = c - 8'h61 + 8'd26;
        res.sextet = diff[5:0];
      end
      [8'h30:8'h39]: begin
        diff       = c - 8'h30 + 8'd52;
        res.sextet = diff[5:0];
      end
      8'h2B: res.sextet = 6'd62;
      8'h2F: res.sextet = 6'd63;
      default: res.valid = 1'b0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

### hdl/base64_stream_decoder_top.sv
// Top level of the base64 stream decoder: front part, entry queue and back part.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
//
// Usage: one base64 character per transfer on the slave channel, tlast on the final
// character of the encoded text. The master channel carries one result per transfer:
// tuser 0 is a decoded byte in tdata[7:0], tuser 1 is the closing status in tdata[9:8]
// (0 ok, 1 illegal character, 2 length not a multiple of four). tlast marks the final
// result caused by one character; a status transfer always has it set.
// Throughput: one character per cycle while the queue is not full. Most characters
// cause at most one result; an unpadded closing character or one after a misplaced
// pad causes two, which leave one after the other from the single output register.
// Each result is written into the queue by the edge that accepts its character and is
// loaded into the output register once that register is free and no earlier result waits.
// When the receiver stalls, results gather in the queue (QDEPTH entries) and
// s_axis_tready_o falls once it is full; no result is lost or repeated.
// Reset clears the group state, empties the queue and drops the output valid.
`default_nettype none

module base64_stream_decoder_top
  import b64d_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] char_in
  input  wire logic        s_axis_tlast_i,   // end_of_input
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [7:0] data_byte, [9:8] status, rest zero
  output logic             m_axis_tuser_o,   // kind
  output logic             m_axis_tlast_o    // last_of_run
);

  logic       push, pop, q_full, q_empty;
  b64d_op_t   wr_op, rd_op;
  b64d_item_t item;

  b64d_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .char_i     (s_axis_tdata_i),
    .end_i      (s_axis_tlast_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .op_o       (wr_op)
  );

  b64d_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wr_op_i (wr_op),
    .pop_i   (pop),
    .rd_op_o (rd_op),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  b64d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_op_i      (rd_op),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_item_o  (item)
  );

  assign m_axis_tdata_o = {6'd0, item.status, item.data_byte};
  assign m_axis_tuser_o = item.kind;
  assign m_axis_tlast_o = item.last;

endmodule

`default_nettype wire

### hdl/b64d_front.sv
// Front part: accepts characters, tracks the group state and builds result entries.
// Depends on b64d_pkg; feeds b64d_queue.
`default_nettype none

module b64d_front
  import b64d_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] char_i,
  input  wire logic       end_i,
  input  wire logic       q_full_i,
  output logic            push_o,
  output b64d_op_t        op_o
);

  logic [1:0] pos_q, pos_d;
  logic [5:0] prev_q, prev_d;
  logic       pad_q, pad_d;
  logic       err_q, err_d;
  logic       accept;
  logic       is_pad;
  b64d_dec_t  dec;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign dec        = b64d_decode(char_i);
  assign is_pad     = (char_i == PAD_CHAR);

  function automatic b64d_item_t data_item(input logic [7:0] b, input logic l);
    return '{kind: KIND_DATA, data_byte: b, status: ST_OK, last: l};
  endfunction

  function automatic b64d_item_t status_item(input b64d_status_e st);
    return '{kind: KIND_STATUS, data_byte: 8'd0, status: st, last: 1'b1};
  endfunction

  always_comb begin
    pos_d  = pos_q;
    prev_d = prev_q;
    pad_d  = pad_q;
    err_d  = err_q;
    push_o = 1'b0;
    op_o   = '{two: 1'b0, first: status_item(ST_OK), second: status_item(ST_OK)};
    if (accept) begin
      pos_d = pos_q + 2'd1;
      if (end_i && pos_q != 2'd3) begin
        push_o   = 1'b1;
        op_o.first = status_item(ST_LENGTH);
        pos_d  = 2'd0;
        prev_d = 6'd0;
        pad_d  = 1'b0;
        err_d  = 1'b0;
      end else begin
        case (pos_q)
          2'd0: begin
            prev_d = dec.sextet;
            err_d  = err_q | !dec.valid;
          end
          2'd1: begin
            push_o     = 1'b1;
            op_o.first = data_item({prev_q, dec.sextet[5:4]}, 1'b1);
            prev_d     = dec.sextet;
            err_d      = err_q | !dec.valid;
          end
          2'd2: begin
            if (is_pad) begin
              pad_d = 1'b1;
            end else begin
              push_o     = 1'b1;
              op_o.first = data_item({prev_q[3:0], dec.sextet[5:2]}, 1'b1);
              prev_d     = dec.sextet;
              err_d      = err_q | !dec.valid;
            end
          end
          default: begin
            push_o = 1'b1;
            if (end_i) begin
              // The closing character is only decoded when no padding applies.
              if (!pad_q && !is_pad) begin
                op_o.two    = 1'b1;
                op_o.first  = data_item({prev_q[1:0], dec.sextet}, 1'b0);
                op_o.second = status_item((err_q || !dec.valid) ? ST_ILLEGAL : ST_OK);
              end else begin
                op_o.first = status_item(err_q ? ST_ILLEGAL : ST_OK);
              end
              prev_d = 6'd0;
              pad_d  = 1'b0;
              err_d  = 1'b0;
            end else if (pad_q) begin
              // A held '=' that was not final padding counts as an illegal zero.
              op_o.two    = 1'b1;
              op_o.first  = data_item({prev_q[3:0], 4'd0}, 1'b0);
              op_o.second = data_item({2'd0, dec.sextet}, 1'b1);
              prev_d      = dec.sextet;
              pad_d       = 1'b0;
              err_d       = 1'b1;
            end else begin
              op_o.first = data_item({prev_q[1:0], dec.sextet}, 1'b1);
              prev_d     = dec.sextet;
              err_d      = err_q | !dec.valid;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 2'd0;
      prev_q <= 6'd0;
      pad_q  <= 1'b0;
      err_q  <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      prev_q <= prev_d;
      pad_q  <= pad_d;
      err_q  <= err_d;
    end
  end

endmodule

`default_nettype wire

### hdl/b64d_queue.sv
// Short queue of result entries between the front and back parts.
// Depends on b64d_pkg for the entry type.
`default_nettype none

module b64d_queue
  import b64d_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire b64d_op_t  wr_op_i,
  input  wire logic      pop_i,
  output b64d_op_t       rd_op_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  b64d_op_t           mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rd_op_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/b64d_back.sv
// Back part: unpacks queue entries into single result transfers through an output register.
// Depends on b64d_pkg; reads from b64d_queue.
`default_nettype none

module b64d_back
  import b64d_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     q_empty_i,
  input  wire b64d_op_t q_op_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output b64d_item_t    out_item_o
);

  logic       out_valid_q;
  b64d_item_t out_item_q, out_item_d;
  logic       second_pending_q;
  b64d_item_t second_q;
  logic       load;

  assign load        = !out_valid_q || out_ready_i;
  assign pop_o       = load && !second_pending_q && !q_empty_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign out_item_d  = second_pending_q ? second_q : q_op_i.first;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_item_q <= out_item_d;
    end
    if (pop_o) begin
      second_q <= q_op_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q      <= 1'b0;
      second_pending_q <= 1'b0;
    end else if (load) begin
      if (second_pending_q) begin
        out_valid_q      <= 1'b1;
        second_pending_q <= 1'b0;
      end else begin
        out_valid_q      <= !q_empty_i;
        second_pending_q <= !q_empty_i && q_op_i.two;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/b64d_checker.sv
// Port-level checks on the output channel of the base64 stream decoder, bound to the top level.
// Depends on base64_stream_decoder_top for the bind target only.
`default_nettype none

module b64d_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [15:0] m_axis_tdata_o,
  input wire logic        m_axis_tuser_o,
  input wire logic        m_axis_tlast_o
);

  // A stalled transfer keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("output transfer changed while stalled");

  // The status item always closes the run of its character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("status transfer without tlast");

  // Status items carry a zero byte and a defined status code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[7:0] == 8'd0
      && m_axis_tdata_o[9:8] != 2'b11)
    else $error("malformed status transfer");

  // Data items carry a zero status and no upper padding bits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o[15:8] == 8'd0)
    else $error("data transfer with nonzero status bits");

endmodule

bind base64_stream_decoder_top b64d_checker u_b64d_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire
